// File: src/stepseq_pkg.sv
package stepseq_pkg;

    // Half-step phase table size and phase counter width
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);

    // Input item kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_BWD  = 2'd1;
    localparam logic [1:0] ACT_HOME = 2'd2;

    // Z pulse codes
    localparam logic [1:0] PULSE_NONE = 2'd0;
    localparam logic [1:0] PULSE_FWD  = 2'd1;
    localparam logic [1:0] PULSE_BWD  = 2'd2;

    // Sequencer state carried between the state register and the step logic
    typedef struct packed {
        logic [PHASE_W-1:0] phase_x;
        logic [PHASE_W-1:0] phase_y;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
        logic [7:0]         pos_z;
        logic               busy;
        logic [1:0]         active_axis;
        logic [1:0]         active_action;
        logic [7:0]         remaining;
    } seq_state_t;

    // One result item
    typedef struct packed {
        logic [1:0] moved_axis;
        logic       stepped;
        logic [3:0] coil_pattern;
        logic [1:0] z_pulse;
        logic [7:0] position;
        logic       end_hit;
        logic       done_res;
    } seq_result_t;

    // Half-step coil pattern for one phase
    function automatic logic [3:0] coil_lookup(input logic [PHASE_W-1:0] phase);
        logic [3:0] coil;
        case (phase)
            3'd0:    coil = 4'h1;
            3'd1:    coil = 4'h5;
            3'd2:    coil = 4'h4;
            3'd3:    coil = 4'h6;
            3'd4:    coil = 4'h2;
            3'd5:    coil = 4'hA;
            3'd6:    coil = 4'h8;
            3'd7:    coil = 4'h9;
            default: coil = 4'h0;
        endcase
        return coil;
    endfunction

endpackage

// File: src/stepseq_core.sv
module stepseq_core (
    input  stepseq_pkg::seq_state_t  state_cur,
    input  logic                     mode,
    input  logic [1:0]               axis,
    input  logic [1:0]               action,
    input  logic [7:0]               step_count,
    input  logic                     end_x,
    input  logic                     end_y,
    input  logic                     end_z,
    output stepseq_pkg::seq_state_t  state_next,
    output stepseq_pkg::seq_result_t result,
    output logic                     result_valid
);

    logic end_closed;
    logic do_step;
    logic step_fwd;
    logic done;

    // Pick the end switch of the active axis
    always_comb begin
        case (state_cur.active_axis)
            stepseq_pkg::AXIS_X: end_closed = end_x;
            stepseq_pkg::AXIS_Y: end_closed = end_y;
            default:             end_closed = end_z;
        endcase
    end

    // Decide the step, update state and build the result
    always_comb begin
        state_next   = state_cur;
        result       = '0;
        result_valid = 1'b0;
        do_step      = 1'b0;
        step_fwd     = 1'b0;
        done         = 1'b0;

        if (mode == stepseq_pkg::MODE_START) begin
            // Load a command; drop bad axis or action codes
            if ((axis == stepseq_pkg::AXIS_X || axis == stepseq_pkg::AXIS_Y ||
                 axis == stepseq_pkg::AXIS_Z) &&
                (action == stepseq_pkg::ACT_FWD || action == stepseq_pkg::ACT_BWD ||
                 action == stepseq_pkg::ACT_HOME)) begin
                state_next.active_axis   = axis;
                state_next.active_action = action;
                state_next.remaining     = step_count;
                state_next.busy          = 1'b1;
            end
        end else if (state_cur.busy) begin
            result_valid = 1'b1;
            if (state_cur.active_action == stepseq_pkg::ACT_HOME) begin
                if (end_closed) begin
                    // Home reached: zero the position
                    case (state_cur.active_axis)
                        stepseq_pkg::AXIS_X: state_next.pos_x = '0;
                        stepseq_pkg::AXIS_Y: state_next.pos_y = '0;
                        default:             state_next.pos_z = '0;
                    endcase
                    result.end_hit = 1'b1;
                    done           = 1'b1;
                end else begin
                    do_step = 1'b1;
                end
            end else if (state_cur.remaining == '0) begin
                done = 1'b1;
            end else if (state_cur.active_action == stepseq_pkg::ACT_BWD && end_closed) begin
                result.end_hit = 1'b1;
                done           = 1'b1;
            end else begin
                do_step              = 1'b1;
                step_fwd             = (state_cur.active_action == stepseq_pkg::ACT_FWD);
                state_next.remaining = state_cur.remaining - 8'd1;
                done                 = (state_cur.remaining == 8'd1);
            end

            // Perform one step on the active axis
            if (do_step) begin
                result.stepped = 1'b1;
                case (state_cur.active_axis)
                    stepseq_pkg::AXIS_X: begin
                        result.coil_pattern = stepseq_pkg::coil_lookup(state_cur.phase_x);
                        state_next.phase_x  = step_fwd ? state_cur.phase_x + 1'b1
                                                       : state_cur.phase_x - 1'b1;
                        state_next.pos_x    = step_fwd ? state_cur.pos_x + 8'd1
                                                       : state_cur.pos_x - 8'd1;
                    end
                    stepseq_pkg::AXIS_Y: begin
                        result.coil_pattern = stepseq_pkg::coil_lookup(state_cur.phase_y);
                        state_next.phase_y  = step_fwd ? state_cur.phase_y + 1'b1
                                                       : state_cur.phase_y - 1'b1;
                        state_next.pos_y    = step_fwd ? state_cur.pos_y + 8'd1
                                                       : state_cur.pos_y - 8'd1;
                    end
                    default: begin
                        result.z_pulse   = step_fwd ? stepseq_pkg::PULSE_FWD
                                                    : stepseq_pkg::PULSE_BWD;
                        state_next.pos_z = step_fwd ? state_cur.pos_z + 8'd1
                                                    : state_cur.pos_z - 8'd1;
                    end
                endcase
            end

            if (done) begin
                state_next.busy = 1'b0;
            end

            // Report the position after this tick
            result.moved_axis = state_cur.active_axis;
            result.done_res   = done;
            case (state_cur.active_axis)
                stepseq_pkg::AXIS_X: result.position = state_next.pos_x;
                stepseq_pkg::AXIS_Y: result.position = state_next.pos_y;
                default:             result.position = state_next.pos_z;
            endcase
        end
    end

endmodule

// File: src/three_axis_stepper_homing_sequencer.sv
// Three-axis stepper sequencer with homing.
// Input channel (s_valid/s_ready): a start item (s_mode = 0) loads axis,
// action and step count for a new command; a tick item (s_mode = 1)
// carries the three end-switch levels and performs at most one step of the
// active command. Start items, ticks while idle, and starts with a bad axis
// or action code produce no result.
// Result channel (m_valid/m_ready): one item per tick while a command is
// active, with coil pattern (X, Y), Z pulse, new position and done flag.
// A result appears in the cycle after its tick is accepted, held in the
// output register. Throughput: one item per cycle unless the receiver
// stalls; step logic is combinational between state and output registers.
// The input side takes a new item while the output register is empty or
// is being drained in the same cycle, so a stalled receiver stops input
// only while a result waits.
// Reset (aresetn low, synchronous) zeroes phases, positions and the active
// command and empties the output register.
module three_axis_stepper_homing_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [1:0] s_axis,
    input  logic [1:0] s_action,
    input  logic [7:0] s_step_count,
    input  logic       s_end_x,
    input  logic       s_end_y,
    input  logic       s_end_z,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_moved_axis,
    output logic       m_stepped,
    output logic [3:0] m_coil_pattern,
    output logic [1:0] m_z_pulse,
    output logic [7:0] m_position,
    output logic       m_end_hit,
    output logic       m_done_res
);

    stepseq_pkg::seq_state_t  state_reg, state_next;
    stepseq_pkg::seq_result_t result_reg, result_next;
    logic                     result_valid;
    logic                     m_valid_reg;
    logic                     s_fire;

    stepseq_core u_core (
        .state_cur    (state_reg),
        .mode         (s_mode),
        .axis         (s_axis),
        .action       (s_action),
        .step_count   (s_step_count),
        .end_x        (s_end_x),
        .end_y        (s_end_y),
        .end_z        (s_end_z),
        .state_next   (state_next),
        .result       (result_next),
        .result_valid (result_valid)
    );

    // Accept while the output register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Advance the sequencer state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Load or drain the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && result_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && result_valid) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_moved_axis   = result_reg.moved_axis;
    assign m_stepped      = result_reg.stepped;
    assign m_coil_pattern = result_reg.coil_pattern;
    assign m_z_pulse      = result_reg.z_pulse;
    assign m_position     = result_reg.position;
    assign m_end_hit      = result_reg.end_hit;
    assign m_done_res     = result_reg.done_res;

endmodule

// File: src/stepseq_checker.sv
module stepseq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_moved_axis,
    input logic       m_stepped,
    input logic [3:0] m_coil_pattern,
    input logic [1:0] m_z_pulse,
    input logic [7:0] m_position,
    input logic       m_end_hit,
    input logic       m_done_res
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_moved_axis) && $stable(m_stepped)
            && $stable(m_coil_pattern) && $stable(m_z_pulse) && $stable(m_position)
            && $stable(m_end_hit) && $stable(m_done_res))
        else $error("stalled result item changed");

    // Input must be open whenever no result is waiting
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // A switch end never comes with a step and always closes the command
    a_end_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_hit |-> !m_stepped && m_done_res)
        else $error("end hit with step or without done");

    // Coil bits only on X or Y steps
    a_coil: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coil_pattern != 4'd0 |->
            m_stepped && m_moved_axis != stepseq_pkg::AXIS_Z
            && m_z_pulse == stepseq_pkg::PULSE_NONE)
        else $error("coil pattern outside an X or Y step");

    // Z pulse only on Z steps
    a_zpulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_z_pulse != stepseq_pkg::PULSE_NONE |->
            m_stepped && m_moved_axis == stepseq_pkg::AXIS_Z)
        else $error("z pulse outside a Z step");

endmodule

bind three_axis_stepper_homing_sequencer stepseq_checker u_stepseq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_moved_axis   (m_moved_axis),
    .m_stepped      (m_stepped),
    .m_coil_pattern (m_coil_pattern),
    .m_z_pulse      (m_z_pulse),
    .m_position     (m_position),
    .m_end_hit      (m_end_hit),
    .m_done_res     (m_done_res)
);
